// ===== hdl/periodic_task_due_scheduler_assert.svh =====
// Assertion macros for the periodic task due scheduler checker.
// Used by pdts_checker; no other dependencies.
`ifndef PERIODIC_TASK_DUE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_DUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define PDTS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pdts: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define PDTS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pdts: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define PDTS_ASSERT_NXT_ALL(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("pdts: reset check failed");

`endif

// ===== hdl/pdts_pkg.sv =====
// Shared types and constants for the periodic task due scheduler.
// No dependencies.
`timescale 1ns / 1ps

package pdts_pkg;

  localparam int TASK_SLOTS    = 8;
  localparam int TASK_W        = 3;
  localparam int TIME_W        = 32;
  localparam int PERIOD_W      = 32;
  localparam int CFG_IDX_W     = 4;
  localparam int Q_DEPTH       = 2;
  localparam int NUM_TASKS_DEF = 8;
  localparam int S_DATA_W      = 40;
  localparam int M_DATA_W      = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [TASK_SLOTS] =
    '{32'd5, 32'd5, 32'd1, 32'd50, 32'd100, 32'd100, 32'd10, 32'd0};

  typedef enum logic {
    OP_SYNC = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // One queued command between front and back.
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now_time;
  } q_entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// ===== hdl/periodic_task_due_scheduler.sv =====
// Periodic task due scheduler, top level.
// Depends on pdts_pkg, pdts_front and pdts_back.
//
// Usage:
//   Slave stream (s_*) takes command words: operation 0 loads every task's
//   last-run time with now_time, operation 1 polls for due tasks.
//   Master stream (m_*) returns one word per due task in index order, with
//   m_tlast on the final due task of a poll; a poll with nothing due gives
//   no word. Period registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; indexes of TASK_SLOTS and above are ignored.
//   Flow: a word passes through a two-entry input queue. A sync is
//   handled in the back end as it is dequeued. A poll there steps through
//   dequeue, each task in turn through the single due-check unit, and a
//   step to release the held final result. Each due index is held until
//   a later due task is found or the scan ends, then enters the output register.
//   Reset restores the default periods, clears all last-run times and
//   empties the queue and the output register.
//   When m_tready is low the output word holds; the scan stalls only when a
//   second due task needs the occupied output slot, and the input queue
//   keeps taking words until it is full.
`timescale 1ns / 1ps

module periodic_task_due_scheduler import pdts_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // [0] operation, [32:1] now_time, [39:33] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [2:0] task_index, [7:3] zero
  output logic                 m_tlast,   // last_due
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data
);

  q_head_t           head;
  logic              pop;
  logic [TASK_W-1:0] task_index;

  pdts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .pop      (pop),
    .head     (head)
  );

  pdts_back #(
    .NUM_TASKS (NUM_TASKS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .task_index (task_index),
    .m_tlast    (m_tlast)
  );

  assign m_tdata = {(M_DATA_W - TASK_W)'(0), task_index};

endmodule

// ===== hdl/pdts_front.sv =====
// Front end: accepts input words, decodes the operation, and queues them.
// Depends on pdts_pkg.
`timescale 1ns / 1ps

module pdts_front import pdts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [0] operation, [32:1] now_time, rest zero
  input  logic                pop,
  output q_head_t             head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t           mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               push;
  logic               do_pop;
  q_entry_t           in_entry;

  // Decode the incoming word
  always_comb begin
    in_entry.op       = s_tdata[0] ? OP_POLL : OP_SYNC;
    in_entry.now_time = s_tdata[TIME_W:1];
  end

  assign s_tready = (count != CNT_W'(Q_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (count != '0);

  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_comb begin
    head.valid = (count != '0);
    head.entry = mem[rd_ptr];
  end

endmodule

// ===== hdl/pdts_back.sv =====
// Back end: holds periods and last-run times, scans one task per cycle
// unless the output stalls it, emits due task indices. Depends on pdts_pkg.
`timescale 1ns / 1ps

module pdts_back import pdts_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  q_head_t              head,
  output logic                 pop,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TASK_W-1:0]    task_index,
  output logic                 m_tlast
);

  localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

  state_t               state;
  state_t               state_next;
  logic [TASK_W-1:0]    idx;
  logic [TIME_W-1:0]    now_q;
  logic                 pend_valid;
  logic [TASK_W-1:0]    pend_idx;
  logic                 out_valid;
  logic [TASK_W-1:0]    out_idx;
  logic                 out_last;
  logic [PERIOD_W-1:0]  period [TASK_SLOTS];
  logic [TIME_W-1:0]    lrt    [TASK_SLOTS];

  logic [PERIOD_W-1:0]  cur_p;
  logic [TIME_W-1:0]    diff;
  logic [TIME_W-1:0]    rem;
  logic                 due;
  logic [TIME_W-1:0]    lrt_new;
  logic                 slot_free;
  logic                 push;
  logic                 push_last;
  logic                 advance;
  logic                 take_due;
  logic                 do_sync;
  logic                 start_poll;

  // Due check for the task under the scan pointer
  always_comb begin
    cur_p   = period[idx];
    diff    = now_q - lrt[idx];
    rem     = diff - cur_p;
    due     = (cur_p != '0) && (diff >= cur_p);
    lrt_new = (rem >= cur_p) ? now_q : (lrt[idx] + cur_p);
  end

  assign slot_free = !out_valid || m_tready;

  // Next state and control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    advance    = 1'b0;
    take_due   = 1'b0;
    do_sync    = 1'b0;
    start_poll = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.entry.op == OP_POLL) begin
            start_poll = 1'b1;
            state_next = ST_SCAN;
          end else begin
            do_sync = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!(due && pend_valid && !slot_free)) begin
          advance  = 1'b1;
          take_due = due;
          push     = due && pend_valid;
          if (idx == LAST_TASK) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan pointer, held time and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (start_poll) begin
        idx        <= '0;
        pend_valid <= 1'b0;
      end else if (advance) begin
        idx <= idx + TASK_W'(1);
        if (take_due) begin
          pend_valid <= 1'b1;
        end
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_poll) begin
      now_q <= head.entry.now_time;
    end
    if (take_due) begin
      pend_idx <= idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_idx  <= pend_idx;
      out_last <= push_last;
    end
  end

  // Period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        period[k] <= PERIOD_RESET[k];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(TASK_SLOTS))) begin
      period[cfg_index[TASK_W-1:0]] <= cfg_data;
    end
  end

  // Last-run times: sync loads all active tasks, a due task updates its own
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        lrt[k] <= '0;
      end
    end else if (do_sync) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        if (k < NUM_TASKS) begin
          lrt[k] <= head.entry.now_time;
        end
      end
    end else if (take_due) begin
      lrt[idx] <= lrt_new;
    end
  end

  assign m_tvalid   = out_valid;
  assign task_index = out_idx;
  assign m_tlast    = out_last;

endmodule

// ===== hdl/pdts_checker.sv =====
// Port-level checks for the periodic task due scheduler, bound to the top.
// Depends on pdts_pkg and periodic_task_due_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "periodic_task_due_scheduler_assert.svh"

module pdts_checker import pdts_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  // Hold a stalled output word
  `PDTS_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `PDTS_ASSERT_NXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  // Come out of reset empty and ready
  `PDTS_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !m_tvalid && s_tready)
  // Keep the padding above the task index at zero
  `PDTS_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[M_DATA_W-1:TASK_W] == '0)

endmodule

bind periodic_task_due_scheduler pdts_checker u_pdts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
